// ----- design/adam_pkg.sv -----
// ----------------------------------------------------------------------------
// Adam update package
// Shared types, register indexes and datapath operation codes.
// ----------------------------------------------------------------------------
package adam_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BETA_ONE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_TWO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_EN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_BOUND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_BOUND = 3'd5;

   localparam logic [6:0] DIV_STEPS  = 7'd96;
   localparam logic [5:0] SQRT_STEPS = 6'd32;

   typedef struct packed {
      logic [15:0]        beta_one;
      logic [15:0]        beta_two;
      logic [15:0]        learn_rate;
      logic               clamp_enable;
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_DEC,
      OP_MA, OP_MB, OP_MC, OP_MD, OP_ME, OP_MF, OP_MG, OP_MH,
      OP_P1, OP_P2, OP_PSQ, OP_PSQW, OP_PML, OP_PMLW,
      OP_D1, OP_D2, OP_D3, OP_DRUN, OP_D1E, OP_D2E,
      OP_SRUN, OP_SQE, OP_L1, OP_L2, OP_D3E, OP_UPD, OP_FIN
   } op_type;

   typedef struct packed {
      logic oor;
      logic is_init;
      logic k_zero;
      logic cur_bit;
      logic pow_sel;
      logic div_done;
      logic sq_done;
      logic rsp_free;
   } sts_type;

   // Index of the highest set bit of a 17 bit exponent.
   function automatic logic [4:0] top_bit(input logic [16:0] e);
      logic [4:0] pos;
      pos = 5'd0;
      for (int i = 0; i < 17; i++) begin
         if (e[i]) pos = 5'(i);
      end
      return pos;
   endfunction

endpackage

// ----- design/adam_csr.sv -----
// ----------------------------------------------------------------------------
// Adam configuration registers
// Holds the decay rates, step size and clamp settings.
// ----------------------------------------------------------------------------
module adam_csr import adam_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beta_one     <= 16'd58982;
         cfg_ff.beta_two     <= 16'd65470;
         cfg_ff.learn_rate   <= 16'd66;
         cfg_ff.clamp_enable <= 1'b0;
         cfg_ff.lower_bound  <= 32'sh8000_0000;
         cfg_ff.upper_bound  <= 32'sh7FFF_FFFF;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_BETA_ONE:    cfg_ff.beta_one     <= csr_wdata[15:0];
            CSR_BETA_TWO:    cfg_ff.beta_two     <= csr_wdata[15:0];
            CSR_LEARN_RATE:  cfg_ff.learn_rate   <= csr_wdata[15:0];
            CSR_CLAMP_EN:    cfg_ff.clamp_enable <= csr_wdata[0];
            CSR_LOWER_BOUND: cfg_ff.lower_bound  <= $signed(csr_wdata);
            CSR_UPPER_BOUND: cfg_ff.upper_bound  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/adam_ctrl.sv -----
// ----------------------------------------------------------------------------
// Adam controller
// Sequences the datapath through the moment, power, divide and root steps.
// ----------------------------------------------------------------------------
module adam_ctrl import adam_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output op_type  cmd
);

   typedef enum logic [31:0] {
      ST_IDLE = 32'h0000_0001, ST_DEC  = 32'h0000_0002, ST_MA   = 32'h0000_0004,
      ST_MB   = 32'h0000_0008, ST_MC   = 32'h0000_0010, ST_MD   = 32'h0000_0020,
      ST_ME   = 32'h0000_0040, ST_MF   = 32'h0000_0080, ST_MG   = 32'h0000_0100,
      ST_MH   = 32'h0000_0200, ST_P1   = 32'h0000_0400, ST_P2   = 32'h0000_0800,
      ST_PCHK = 32'h0000_1000, ST_PSQ  = 32'h0000_2000, ST_PSQW = 32'h0000_4000,
      ST_PML  = 32'h0000_8000, ST_PMLW = 32'h0001_0000, ST_D1   = 32'h0002_0000,
      ST_D1W  = 32'h0004_0000, ST_D1E  = 32'h0008_0000, ST_D2   = 32'h0010_0000,
      ST_D2W  = 32'h0020_0000, ST_D2E  = 32'h0040_0000, ST_SQW  = 32'h0080_0000,
      ST_SQE  = 32'h0100_0000, ST_L1   = 32'h0200_0000, ST_L2   = 32'h0400_0000,
      ST_D3   = 32'h0800_0000, ST_D3W  = 32'h1000_0000, ST_D3E  = 32'h2000_0000,
      ST_UPD  = 32'h4000_0000, ST_FIN  = 32'h8000_0000
   } state_type;

   state_type state_ff, state_in;
   state_type pow_next;

   assign req_tready = (state_ff == ST_IDLE);
   // After the first power the second follows; after the second, the divisions.
   assign pow_next = sts.pow_sel ? ST_D1 : ST_P2;

   always_comb begin
      state_in = state_ff;
      cmd      = OP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd      = OP_LOAD;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            cmd      = OP_DEC;
            state_in = (sts.oor || sts.is_init) ? ST_FIN : ST_MA;
         end
         ST_MA: begin cmd = OP_MA; state_in = ST_MB; end
         ST_MB: begin cmd = OP_MB; state_in = ST_MC; end
         ST_MC: begin cmd = OP_MC; state_in = ST_MD; end
         ST_MD: begin cmd = OP_MD; state_in = ST_ME; end
         ST_ME: begin cmd = OP_ME; state_in = ST_MF; end
         ST_MF: begin cmd = OP_MF; state_in = ST_MG; end
         ST_MG: begin cmd = OP_MG; state_in = ST_MH; end
         ST_MH: begin cmd = OP_MH; state_in = ST_P1; end
         ST_P1: begin cmd = OP_P1; state_in = ST_PCHK; end
         ST_P2: begin cmd = OP_P2; state_in = ST_PCHK; end
         ST_PCHK: state_in = sts.k_zero ? pow_next : ST_PSQ;
         ST_PSQ: begin cmd = OP_PSQ; state_in = ST_PSQW; end
         ST_PSQW: begin
            cmd      = OP_PSQW;
            state_in = sts.cur_bit ? ST_PML : ST_PCHK;
         end
         ST_PML: begin cmd = OP_PML; state_in = ST_PMLW; end
         ST_PMLW: begin cmd = OP_PMLW; state_in = ST_PCHK; end
         ST_D1: begin cmd = OP_D1; state_in = ST_D1W; end
         ST_D1W: begin
            cmd = OP_DRUN;
            if (sts.div_done) state_in = ST_D1E;
         end
         ST_D1E: begin cmd = OP_D1E; state_in = ST_D2; end
         ST_D2: begin cmd = OP_D2; state_in = ST_D2W; end
         ST_D2W: begin
            cmd = OP_DRUN;
            if (sts.div_done) state_in = ST_D2E;
         end
         ST_D2E: begin cmd = OP_D2E; state_in = ST_SQW; end
         ST_SQW: begin
            cmd = OP_SRUN;
            if (sts.sq_done) state_in = ST_SQE;
         end
         ST_SQE: begin cmd = OP_SQE; state_in = ST_L1; end
         ST_L1: begin cmd = OP_L1; state_in = ST_L2; end
         ST_L2: begin cmd = OP_L2; state_in = ST_D3; end
         ST_D3: begin cmd = OP_D3; state_in = ST_D3W; end
         ST_D3W: begin
            cmd = OP_DRUN;
            if (sts.div_done) state_in = ST_D3E;
         end
         ST_D3E: begin cmd = OP_D3E; state_in = ST_UPD; end
         ST_UPD: begin cmd = OP_UPD; state_in = ST_FIN; end
         ST_FIN: begin
            if (sts.rsp_free) begin
               cmd      = OP_FIN;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- design/adam_dp.sv -----
// ----------------------------------------------------------------------------
// Adam datapath
// Element stores, shared multiplier, shared divider, square root unit and
// the output register.
// ----------------------------------------------------------------------------
module adam_dp import adam_pkg::*; #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  op_type      cmd,
   input  cfg_type     cfg,
   input  logic        in_action,
   input  logic [9:0]  in_index,
   input  logic [31:0] in_value,
   input  logic [15:0] in_step,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [9:0]  rsp_index,
   output logic [31:0] rsp_weight,
   output sts_type     sts
);

   localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

   logic [31:0] w_mem [VECTOR_DEPTH];
   logic [31:0] m_mem [VECTOR_DEPTH];
   logic [63:0] v_mem [VECTOR_DEPTH];

   logic [9:0]  idx_ff;
   logic        act_ff;
   logic [31:0] val_ff;
   logic [16:0] e_ff;
   logic [31:0] rd_w_ff, rd_m_ff;
   logic [63:0] rd_v_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic        in_range;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff, acc_ff, hh_ff;
   logic signed [65:0] msum, mrnd, llsum, rnd_p;
   logic [31:0] m_ff, m_abs, g_abs;
   logic [63:0] gg_ff, v_ff;

   logic [31:0] base_ff, r_ff;
   logic [4:0]  k_ff;
   logic        sel_ff;
   logic [32:0] d1_ff, d2_ff;

   logic [95:0] div_num_ff;
   logic [31:0] div_rem_ff;
   logic [32:0] div_den_ff, div_rs, div_diff;
   logic [63:0] div_q_ff, div_res;
   logic        div_ovf_ff, div_ge;
   logic [6:0]  div_cnt_ff;

   logic [63:0] sq_x_ff, sq_res_ff, sq_bit_ff, sq_sum;
   logic [5:0]  sq_cnt_ff;

   logic [63:0] amh_ff;
   logic [31:0] denom_ff;
   logic [32:0] delta_ff;
   logic [80:0] num81;

   logic signed [34:0] wsum;
   logic signed [31:0] wsat, wupd;
   logic [1:0]  bc_ff, bc_nx;
   logic [31:0] wres_ff;
   logic        rsp_valid_ff;
   logic [9:0]  rsp_idx_ff;
   logic [31:0] rsp_w_ff;

   assign in_range = (32'(idx_ff) < VECTOR_DEPTH);

   // Element stores: registered read at accept, write when the result leaves.
   always_ff @(posedge clock) begin
      if (cmd == OP_LOAD) begin
         rd_w_ff <= w_mem[ADDR_W'(in_index)];
         rd_m_ff <= m_mem[ADDR_W'(in_index)];
         rd_v_ff <= v_mem[ADDR_W'(in_index)];
      end
      if (cmd == OP_FIN && in_range) begin
         w_mem[addr_ff] <= act_ff ? wres_ff : val_ff;
         m_mem[addr_ff] <= act_ff ? m_ff : 32'd0;
         v_mem[addr_ff] <= act_ff ? v_ff : 64'd0;
      end
   end

   assign g_abs = val_ff[31] ? (~val_ff + 32'd1) : val_ff;
   assign m_abs = m_ff[31] ? (~m_ff + 32'd1) : m_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd)
         OP_MA: begin mul_a = {17'd0, cfg.beta_one}; mul_b = {rd_m_ff[31], rd_m_ff}; end
         OP_MB: begin
            mul_a = {16'd0, 17'h1_0000 - {1'b0, cfg.beta_one}};
            mul_b = {val_ff[31], val_ff};
         end
         OP_MC: begin mul_a = {1'b0, g_abs}; mul_b = {1'b0, g_abs}; end
         OP_MD: begin mul_a = {17'd0, cfg.beta_two}; mul_b = {1'b0, rd_v_ff[63:32]}; end
         OP_ME: begin
            mul_a = {16'd0, 17'h1_0000 - {1'b0, cfg.beta_two}};
            mul_b = {1'b0, gg_ff[63:32]};
         end
         OP_MF: begin mul_a = {17'd0, cfg.beta_two}; mul_b = {1'b0, rd_v_ff[31:0]}; end
         OP_MG: begin
            mul_a = {16'd0, 17'h1_0000 - {1'b0, cfg.beta_two}};
            mul_b = {1'b0, gg_ff[31:0]};
         end
         OP_PSQ: begin mul_a = {1'b0, r_ff}; mul_b = {1'b0, r_ff}; end
         OP_PML: begin mul_a = {1'b0, r_ff}; mul_b = {1'b0, base_ff}; end
         OP_L1:  begin mul_a = {17'd0, cfg.learn_rate}; mul_b = {1'b0, amh_ff[31:0]}; end
         OP_L2:  begin mul_a = {17'd0, cfg.learn_rate}; mul_b = {1'b0, amh_ff[63:32]}; end
         default: ;
      endcase
   end

   assign msum  = acc_ff + prod_ff;
   assign mrnd  = (msum + 66'sd32768) >>> 16;
   assign llsum = acc_ff + prod_ff;
   assign rnd_p = prod_ff + 66'sh0_8000_0000;

   // One restoring division step: a quotient bit leaving the top marks overflow.
   assign div_rs   = {div_rem_ff, div_num_ff[95]};
   assign div_ge   = (div_rs >= div_den_ff);
   assign div_diff = div_rs - div_den_ff;
   assign div_res  = div_ovf_ff ? '1 : div_q_ff;

   assign sq_sum = sq_res_ff + sq_bit_ff;
   assign num81  = 81'(acc_ff) + (81'(prod_ff) << 32) + 81'(denom_ff >> 1);

   // Weight step, saturation and clamp.
   always_comb begin
      if (m_ff[31]) wsum = 35'(signed'(rd_w_ff)) + signed'({2'b00, delta_ff});
      else          wsum = 35'(signed'(rd_w_ff)) - signed'({2'b00, delta_ff});
      if (wsum > 35'sd2147483647)       wsat = 32'sh7FFF_FFFF;
      else if (wsum < -35'sd2147483648) wsat = 32'sh8000_0000;
      else                              wsat = wsum[31:0];
      bc_nx = (bc_ff == 2'd3) ? 2'd3 : bc_ff + 2'd1;
      wupd  = wsat;
      if (cfg.clamp_enable && bc_nx > 2'd1) begin
         if (wupd < cfg.lower_bound) wupd = cfg.lower_bound;
         if (wupd > cfg.upper_bound) wupd = cfg.upper_bound;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd)
         OP_LOAD: begin
            idx_ff  <= in_index;
            act_ff  <= in_action;
            val_ff  <= in_value;
            e_ff    <= 17'(in_step) + 17'd1;
            addr_ff <= ADDR_W'(in_index);
         end
         OP_DEC: wres_ff <= in_range ? val_ff : 32'd0;
         OP_MB:  acc_ff <= prod_ff;
         OP_MC:  m_ff <= mrnd[31:0];
         OP_MD:  gg_ff <= prod_ff[63:0];
         OP_ME:  acc_ff <= prod_ff;
         OP_MF:  hh_ff <= acc_ff + prod_ff;
         OP_MG:  acc_ff <= prod_ff;
         OP_MH:  v_ff <= 64'((hh_ff <<< 16) + ((llsum + 66'sd32768) >>> 16));
         OP_P1: begin
            base_ff <= {cfg.beta_one, 16'h0};
            r_ff    <= {cfg.beta_one, 16'h0};
            k_ff    <= top_bit(e_ff);
            sel_ff  <= 1'b0;
         end
         OP_P2: begin
            d1_ff   <= 33'h1_0000_0000 - {1'b0, r_ff};
            base_ff <= {cfg.beta_two, 16'h0};
            r_ff    <= {cfg.beta_two, 16'h0};
            k_ff    <= top_bit(e_ff);
            sel_ff  <= 1'b1;
         end
         OP_PSQ:  k_ff <= k_ff - 5'd1;
         OP_PSQW: r_ff <= rnd_p[63:32];
         OP_PMLW: r_ff <= rnd_p[63:32];
         OP_D1: begin
            d2_ff      <= 33'h1_0000_0000 - {1'b0, r_ff};
            div_num_ff <= {32'd0, m_abs, 32'd0};
            div_den_ff <= d1_ff;
         end
         OP_D2: begin
            div_num_ff <= {v_ff, 32'd0};
            div_den_ff <= d2_ff;
         end
         OP_D3: begin
            div_num_ff <= {15'd0, num81};
            div_den_ff <= {1'b0, denom_ff};
         end
         OP_DRUN: begin
            if (div_cnt_ff != 7'd0) begin
               div_num_ff <= {div_num_ff[94:0], 1'b0};
               div_rem_ff <= div_ge ? div_diff[31:0] : div_rs[31:0];
               div_q_ff   <= {div_q_ff[62:0], div_ge};
               div_ovf_ff <= div_ovf_ff | div_q_ff[63];
            end
         end
         OP_D1E: amh_ff <= div_res;
         OP_D2E: begin
            sq_x_ff   <= (&div_res) ? div_res : div_res + 64'd1;
            sq_res_ff <= 64'd0;
            sq_bit_ff <= 64'h4000_0000_0000_0000;
         end
         OP_SRUN: begin
            if (sq_cnt_ff != 6'd0) begin
               if (sq_x_ff >= sq_sum) begin
                  sq_x_ff   <= sq_x_ff - sq_sum;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
            end
         end
         OP_SQE: denom_ff <= sq_res_ff[31:0];
         OP_L2:  acc_ff <= prod_ff;
         OP_D3E: delta_ff <= (div_ovf_ff || div_q_ff > 64'h1_0000_0000) ?
                             33'h1_0000_0000 : div_q_ff[32:0];
         OP_UPD: wres_ff <= wupd;
         OP_FIN: begin
            rsp_idx_ff <= idx_ff;
            rsp_w_ff   <= wres_ff;
         end
         default: ;
      endcase
      if (cmd == OP_D1 || cmd == OP_D2 || cmd == OP_D3) begin
         div_rem_ff <= 32'd0;
         div_q_ff   <= 64'd0;
         div_ovf_ff <= 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff   <= 7'd0;
         sq_cnt_ff    <= 6'd0;
         bc_ff        <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd == OP_D1 || cmd == OP_D2 || cmd == OP_D3) div_cnt_ff <= DIV_STEPS;
         else if (cmd == OP_DRUN && div_cnt_ff != 7'd0)   div_cnt_ff <= div_cnt_ff - 7'd1;
         if (cmd == OP_D2E)                              sq_cnt_ff <= SQRT_STEPS;
         else if (cmd == OP_SRUN && sq_cnt_ff != 6'd0)   sq_cnt_ff <= sq_cnt_ff - 6'd1;
         if (cmd == OP_DEC && in_range && !act_ff)        bc_ff <= 2'd0;
         else if (cmd == OP_UPD && cfg.clamp_enable)      bc_ff <= bc_nx;
         if (cmd == OP_FIN)   rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      sts.oor      = !in_range;
      sts.is_init  = !act_ff;
      sts.k_zero   = (k_ff == 5'd0);
      sts.cur_bit  = e_ff[k_ff];
      sts.pow_sel  = sel_ff;
      sts.div_done = (div_cnt_ff == 7'd0);
      sts.sq_done  = (sq_cnt_ff == 6'd0);
      sts.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_index  = rsp_idx_ff;
   assign rsp_weight = rsp_w_ff;

endmodule

// ----- design/adam_update_with_clamp.sv -----
// ----------------------------------------------------------------------------
// Adam update with clamp
// Per-element Adam optimiser step over a stored weight vector.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_* either initialises an element (tuser low: store the
//   weight, clear its moments and the bound counter) or runs one optimiser
//   step on it (tuser high: operand is the gradient, step_count the t used
//   for bias correction). Each request yields one response on rsp_* with the
//   element index and the resulting weight. The user must write configuration
//   on csr_* only while no request is in flight; the block does not enforce it.
//   An init or out-of-range request goes from acceptance through the decode
//   and finish states to the response register, and the next request can be
//   accepted once the engine is back in idle. A step runs from acceptance to
//   response through seven multiplies for the moments, two square-and-multiply
//   powers on the shared multiplier (a square for each bit below the top set
//   bit of t+1 and a multiply for each set bit among them), three runs of the
//   shared restoring divider and a square root. One request is processed at a time.
//   The response register frees the engine: the next request is accepted
//   while a response waits; a stalled receiver holds the engine only at the
//   end of the following request. Reset restores the register defaults and
//   empties the response register; element stores hold no reset value.
// ----------------------------------------------------------------------------
module adam_update_with_clamp import adam_pkg::*; #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,  // elem_index, operand_value, step_count
   input  logic                  req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,  // out_index, new_weight
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   sts_type     sts;
   op_type      cmd;
   logic [9:0]  rsp_index;
   logic [31:0] rsp_weight;

   adam_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   adam_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   adam_dp #(.VECTOR_DEPTH(VECTOR_DEPTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .in_action  (req_tuser),
      .in_index   (req_tdata[9:0]),
      .in_value   (req_tdata[41:10]),
      .in_step    (req_tdata[57:42]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_index  (rsp_index),
      .rsp_weight (rsp_weight),
      .sts        (sts)
   );

   assign rsp_tdata = {6'd0, rsp_weight, rsp_index};

endmodule

// ----- bench/adam_update_with_clamp_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adam update with clamp testbench
// Sends init and step requests through the streaming ports under random
// bursts and receiver stalls. Every weight returned is checked against a
// fixed point Adam predictor kept in the bench, across several register
// settings that include the extremes.
// ----------------------------------------------------------------------------
module adam_update_with_clamp_tb;
   import adam_pkg::*;

   localparam int  DEPTH       = 1024;
   localparam int  PHASE_ITEMS = 165;
   localparam int  CYCLE_LIMIT = 4000000;
   localparam bit  ACT_INIT    = 1'b0;
   localparam bit  ACT_STEP    = 1'b1;

   typedef struct {
      bit          action;
      logic [9:0]  index;
      logic [31:0] operand;
      logic [15:0] step;
      bit          typed;
      logic [31:0] weight;
   } dir_row_type;

   typedef struct {
      logic [9:0]  index;
      logic [31:0] weight;
   } weight_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [47:0]           rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cfg_type        cfg;
   logic [31:0]    weight_mem [DEPTH];
   logic [31:0]    mom1_mem [DEPTH];
   logic [63:0]    mom2_mem [DEPTH];
   bit             written [DEPTH];
   logic [1:0]     clamp_count;
   weight_rsp_type pending_weights [$];
   dir_row_type    dir_tab [$];
   int             fail_count = 0;
   int             sent_count = 0;
   int             step_count_sent = 0;
   int             rsp_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             stall_left = 0;
   logic [9:0]     live_idx [$];

   adam_update_with_clamp dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Beta in Q0.16 raised to e, result in Q0.32, square-and-multiply from
   // the top set bit with each product rounded half up.
   function automatic longint unsigned beta_power(logic [15:0] b, logic [16:0] e);
      longint unsigned base, r;
      int top;
      base = longint'(b) << 16;
      r = base;
      top = 16;
      while (top > 0 && e[top] == 1'b0) top--;
      for (int k = top - 1; k >= 0; k--) begin
         r = (r * r + 64'h8000_0000) >> 32;
         if (e[k]) r = (r * base + 64'h8000_0000) >> 32;
      end
      return r;
   endfunction

   function automatic longint unsigned corr_divide(longint unsigned num,
                                                   longint unsigned den);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      if ((q >> 32) != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
      return (q << 32) + ((r << 32) / den);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] adam_weight(bit action, logic [9:0] idx,
                                               logic [31:0] opv, logic [15:0] t);
      longint g, m, w, mh, lo, hi, b1;
      longint unsigned ag, v, gg, hh, ll, d1, d2, amh, vh, denom, delta, b2;
      if (action == ACT_INIT) begin
         weight_mem[idx] = opv;
         mom1_mem[idx] = '0;
         mom2_mem[idx] = '0;
         clamp_count = 2'd0;
         return opv;
      end
      b1 = cfg.beta_one;
      b2 = cfg.beta_two;
      g = longint'(signed'(opv));
      ag = (g < 0) ? -g : g;
      m = b1 * longint'(signed'(mom1_mem[idx])) + (65536 - b1) * g;
      m = (m + 32768) >>> 16;
      mom1_mem[idx] = m[31:0];
      v = mom2_mem[idx];
      gg = ag * ag;
      hh = b2 * (v >> 32) + (65536 - b2) * (gg >> 32);
      ll = b2 * (v & 64'hFFFF_FFFF) + (65536 - b2) * (gg & 64'hFFFF_FFFF);
      v = (hh << 16) + ((ll + 32768) >> 16);
      mom2_mem[idx] = v;
      d1 = (64'd1 << 32) - beta_power(cfg.beta_one, {1'b0, t} + 17'd1);
      d2 = (64'd1 << 32) - beta_power(cfg.beta_two, {1'b0, t} + 17'd1);
      amh = corr_divide((m < 0) ? -m : m, d1);
      mh = (m < 0) ? -longint'(amh) : longint'(amh);
      vh = corr_divide(v, d2);
      if (vh != 64'hFFFF_FFFF_FFFF_FFFF) vh += 1;
      denom = root_floor(vh);
      delta = (longint'(cfg.learn_rate) * amh + (denom >> 1)) / denom;
      if (delta > (64'd1 << 32)) delta = 64'd1 << 32;
      w = longint'(signed'(weight_mem[idx]));
      w = (mh < 0) ? w + longint'(delta) : w - longint'(delta);
      if (w > 64'sh7FFF_FFFF) w = 64'sh7FFF_FFFF;
      if (w < -64'sh8000_0000) w = -64'sh8000_0000;
      if (cfg.clamp_enable) begin
         if (clamp_count < 2'd3) clamp_count++;
         if (clamp_count > 2'd1) begin
            lo = longint'(cfg.lower_bound);
            hi = longint'(cfg.upper_bound);
            if (w < lo) w = lo;
            if (w > hi) w = hi;
         end
      end
      weight_mem[idx] = w[31:0];
      return w[31:0];
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_BETA_ONE:    cfg.beta_one = data[15:0];
         CSR_BETA_TWO:    cfg.beta_two = data[15:0];
         CSR_LEARN_RATE:  cfg.learn_rate = data[15:0];
         CSR_CLAMP_EN:    cfg.clamp_enable = data[0];
         CSR_LOWER_BOUND: cfg.lower_bound = data;
         CSR_UPPER_BOUND: cfg.upper_bound = data;
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [15:0] b1, logic [15:0] b2, logic [15:0] lr,
                           logic ce, logic [31:0] lo, logic [31:0] hi);
      write_reg(CSR_BETA_ONE, {16'hFFFF, b1});
      write_reg(CSR_BETA_TWO, {16'h0000, b2});
      write_reg(CSR_LEARN_RATE, {16'hA5A5, lr});
      write_reg(CSR_CLAMP_EN, {31'h7FFF_FFFE, ce});
      write_reg(CSR_LOWER_BOUND, lo);
      write_reg(CSR_UPPER_BOUND, hi);
      // An unused index must leave every register alone.
      write_reg(CSR_UPPER_BOUND + 3'd1 + 3'($urandom_range(0, 1)), $urandom);
   endtask

   task automatic send_request(bit action, logic [9:0] idx, logic [31:0] opv,
                               logic [15:0] t, bit typed, logic [31:0] typed_w);
      weight_rsp_type exp_rsp;
      logic [31:0] pred;
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {6'd0, t, opv, idx};
      do @(posedge clock); while (!req_tready);
      pred = adam_weight(action, idx, opv, t);
      exp_rsp.index = idx;
      exp_rsp.weight = typed ? typed_w : pred;
      pending_weights.push_back(exp_rsp);
      if (action == ACT_INIT && !written[idx]) begin
         written[idx] = 1'b1;
         live_idx.push_back(idx);
      end
      sent_count++;
      if (action == ACT_STEP) step_count_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
   endtask

   task automatic drain_requests();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_phase(int count, int pool);
      logic [9:0]  idx;
      logic [31:0] opv;
      logic [15:0] t;
      bit          action;
      for (int n = 0; n < count; n++) begin
         action = ($urandom_range(0, 99) < 75) ? ACT_STEP : ACT_INIT;
         if (action == ACT_INIT || live_idx.size() == 0) begin
            action = ACT_INIT;
            idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, pool));
         end else begin
            idx = live_idx[$urandom_range(0, live_idx.size() - 1)];
            if ($urandom_range(0, 2) != 0 && written[10'(pool)]) idx = 10'(pool);
         end
         case ($urandom_range(0, 3))
            0: opv = $urandom;
            1: opv = 32'($signed($urandom_range(0, 262143)) - 131072);
            2: opv = {{12{1'($urandom)}}, 20'($urandom)};
            default: opv = 32'($signed($urandom_range(0, 8191)) - 4096) << 8;
         endcase
         t = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
         send_request(action, idx, opv, t, 1'b0, '0);
      end
      drain_requests();
   endtask

   // Receiver: ready in random runs, with stalls of varied length.
   always @(posedge clock) begin
      weight_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (pending_weights.size() == 0) begin
            $error("Response with no request waiting: index %0d weight %h",
                   rsp_tdata[9:0], rsp_tdata[41:10]);
            fail_count++;
         end else begin
            exp_rsp = pending_weights.pop_front();
            if (rsp_tdata[9:0] !== exp_rsp.index) begin
               $error("out_index: expected %0d, got %0d", exp_rsp.index, rsp_tdata[9:0]);
               fail_count++;
            end
            if (rsp_tdata[41:10] !== exp_rsp.weight) begin
               $error("new_weight: expected %h, got %h", exp_rsp.weight, rsp_tdata[41:10]);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      cfg.beta_one = 16'd58982;
      cfg.beta_two = 16'd65470;
      cfg.learn_rate = 16'd66;
      cfg.clamp_enable = 1'b0;
      cfg.lower_bound = 32'sh8000_0000;
      cfg.upper_bound = 32'sh7FFF_FFFF;
      clamp_count = 2'd0;
      foreach (written[i]) written[i] = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      dir_tab.push_back('{ACT_INIT, 10'd0, 32'h7FFF_FFFF, 16'd0, 1'b1, 32'h7FFF_FFFF});
      dir_tab.push_back('{ACT_INIT, 10'd1023, 32'h8000_0000, 16'hFFFF, 1'b1, 32'h8000_0000});
      dir_tab.push_back('{ACT_INIT, 10'd512, 32'h0000_0000, 16'd3, 1'b1, 32'h0000_0000});
      dir_tab.push_back('{ACT_STEP, 10'd0, 32'h7FFF_FFFF, 16'd0, 1'b0, '0});
      dir_tab.push_back('{ACT_STEP, 10'd1023, 32'h8000_0000, 16'hFFFF, 1'b0, '0});
      dir_tab.push_back('{ACT_STEP, 10'd512, 32'h0000_0000, 16'd0, 1'b0, '0});
      dir_tab.push_back('{ACT_STEP, 10'd0, 32'h8000_0000, 16'd1, 1'b0, '0});
      dir_tab.push_back('{ACT_STEP, 10'd1023, 32'h0000_0001, 16'h8000, 1'b0, '0});
      dir_tab.push_back('{ACT_STEP, 10'd512, 32'hFFFF_FFFF, 16'h7FFF, 1'b0, '0});
      dir_tab.push_back('{ACT_INIT, 10'd341, 32'h5555_5555, 16'hAAAA, 1'b1, 32'h5555_5555});
      dir_tab.push_back('{ACT_STEP, 10'd341, 32'hAAAA_AAAA, 16'h5555, 1'b0, '0});
      dir_tab.push_back('{ACT_STEP, 10'd341, 32'h0001_0000, 16'd2, 1'b0, '0});
      foreach (dir_tab[i])
         send_request(dir_tab[i].action, dir_tab[i].index, dir_tab[i].operand,
                      dir_tab[i].step, dir_tab[i].typed, dir_tab[i].weight);
      drain_requests();

      random_phase(PHASE_ITEMS, 15);
      set_regs(16'd0, 16'd0, 16'd66, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
      random_phase(PHASE_ITEMS, 31);
      set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
      random_phase(PHASE_ITEMS, 7);
      set_regs(16'd32768, 16'd60000, 16'd0, 1'b1, 32'hFFFF_0000, 32'h0001_0000);
      random_phase(PHASE_ITEMS, 3);
      set_regs(16'd58982, 16'd65470, 16'd4000, 1'b1, 32'h0000_8000, 32'h0004_0000);
      random_phase(PHASE_ITEMS, 5);
      // Lower bound above the upper bound: every clamped weight is the upper.
      set_regs(16'd50000, 16'd65000, 16'd20000, 1'b1, 32'h0010_0000, 32'hFFF0_0000);
      random_phase(PHASE_ITEMS, 2);
      set_regs(16'd1, 16'd1, 16'd1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
      random_phase(PHASE_ITEMS, 1023);

      repeat (100) @(posedge clock);
      $display("Sent %0d requests (%0d optimiser steps) over seven register settings.",
               sent_count, step_count_sent);
      $display("Checked %0d responses, %0d mismatches or strays.", rsp_count, fail_count);
      if (fail_count == 0 && pending_weights.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
